/* design/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg - shared types for the linear key/value table
// Request codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

	localparam int unsigned KEY_W = 64;
	localparam int unsigned VAL_W = 64;
	localparam int unsigned REQ_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_GET    = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CLEAR,
		ST_COMMIT
	} state_t;

endpackage

`default_nettype wire

/* design/lkv_ram.sv */
// ----------------------------------------------------------------------------
// lkv_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/linear_key_value_table_core.sv */
// ----------------------------------------------------------------------------
// linear_key_value_table_core - linear-scan key/value table
// Fixed-capacity table; a zero value marks a slot as empty.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the slave stream (s_*): s_tuser carries the request
//   code (insert, get, clear), s_tdata carries key and value. Every request
//   gives exactly one result word on the master stream (m_*): m_tdata holds
//   the value found by a get (zero otherwise), m_tuser flags a dropped insert
//   on a full table.
//   Insert and get walk all CAPACITY slots through one key compare and one
//   zero detect, one slot per cycle out of the key and value RAMs; no new
//   request is taken until the current one has committed its result.
//   Clear writes zero into every value slot, one per cycle. An unused
//   request code returns an all-zero result.
//   After reset a sweep over every slot zeroes both stores; s_tready stays
//   low until it is done.
//   The result sits in an output register, so the next request is taken
//   while a result still waits. If the receiver stalls, the finished request
//   holds in its commit step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table_core #(
	parameter int unsigned CAPACITY = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // [63:0] key, [127:64] value
	input  wire logic [1:0]   s_tuser,   // [1:0] req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [63:0]  m_tdata,   // [63:0] read_value
	output logic      [0:0]   m_tuser    // [0] table_full
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

	lkv_pkg::state_t state_q, state_nx;

	// request word held for the whole scan
	lkv_pkg::req_t              req_q;
	logic [lkv_pkg::KEY_W-1:0]  key_q;
	logic [lkv_pkg::VAL_W-1:0]  value_q;

	// slot counter shared by the scan, the clear sweep and the reset sweep
	logic [AW-1:0] cnt_q;

	// read data from the RAMs belongs to slot rd_idx_q when rd_vld_q is set
	logic          rd_vld_q;
	logic [AW-1:0] rd_idx_q;

	// scan results
	logic                      hit_q;
	logic [AW-1:0]             hit_idx_q;
	logic [lkv_pkg::VAL_W-1:0] hit_val_q;
	logic                      emp_q;
	logic [AW-1:0]             emp_idx_q;

	// RAM ports
	logic                      key_we, val_we;
	logic [AW-1:0]             waddr;
	logic [lkv_pkg::KEY_W-1:0] key_wdata;
	logic [lkv_pkg::VAL_W-1:0] val_wdata;
	logic [lkv_pkg::KEY_W-1:0] key_rdata;
	logic [lkv_pkg::VAL_W-1:0] val_rdata;

	logic in_acc;
	logic out_free;
	logic commit;
	logic key_eq;
	logic val_zero;
	logic ins_new;
	logic ins_full;
	logic last_slot;

	lkv_ram #(
		.WIDTH(lkv_pkg::KEY_W),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(waddr),
		.wdata(key_wdata),
		.raddr(cnt_q),
		.rdata(key_rdata)
	);

	lkv_ram #(
		.WIDTH(lkv_pkg::VAL_W),
		.DEPTH(CAPACITY)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(waddr),
		.wdata(val_wdata),
		.raddr(cnt_q),
		.rdata(val_rdata)
	);

	// shared compare unit: one slot per cycle
	assign key_eq   = (key_rdata == key_q);
	assign val_zero = (val_rdata == '0);

	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign commit    = (state_q == lkv_pkg::ST_COMMIT) && out_free;
	assign last_slot = (cnt_q == LAST_IDX);

	// insert of an absent key with a nonzero value: needs an empty slot
	assign ins_new  = (req_q == lkv_pkg::REQ_INSERT) && !hit_q && (value_q != '0);
	assign ins_full = ins_new && !emp_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lkv_pkg::ST_INIT: begin
				if (last_slot) state_nx = lkv_pkg::ST_IDLE;
			end
			lkv_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (lkv_pkg::req_t'(s_tuser))
						lkv_pkg::REQ_INSERT, lkv_pkg::REQ_GET: state_nx = lkv_pkg::ST_SCAN;
						lkv_pkg::REQ_CLEAR:                    state_nx = lkv_pkg::ST_CLEAR;
						default:                               state_nx = lkv_pkg::ST_COMMIT;
					endcase
				end
			end
			lkv_pkg::ST_SCAN: begin
				if (last_slot) state_nx = lkv_pkg::ST_DRAIN;
			end
			lkv_pkg::ST_DRAIN: begin
				state_nx = lkv_pkg::ST_COMMIT;
			end
			lkv_pkg::ST_CLEAR: begin
				if (last_slot) state_nx = lkv_pkg::ST_COMMIT;
			end
			lkv_pkg::ST_COMMIT: begin
				if (out_free) state_nx = lkv_pkg::ST_IDLE;
			end
			default: begin
				state_nx = lkv_pkg::ST_INIT;
			end
		endcase
	end

	// outputs of the sequencer: handshake and RAM writes
	always_comb begin
		s_tready  = 1'b0;
		key_we    = 1'b0;
		val_we    = 1'b0;
		waddr     = cnt_q;
		key_wdata = '0;
		val_wdata = '0;
		case (state_q)
			lkv_pkg::ST_INIT: begin
				key_we = 1'b1;
				val_we = 1'b1;
			end
			lkv_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			lkv_pkg::ST_CLEAR: begin
				val_we = 1'b1;
			end
			lkv_pkg::ST_COMMIT: begin
				// overwrite the matching slot, or claim the first empty one
				if (req_q == lkv_pkg::REQ_INSERT) begin
					waddr     = hit_q ? hit_idx_q : emp_idx_q;
					key_wdata = key_q;
					val_wdata = value_q;
					key_we    = commit && ins_new && emp_q;
					val_we    = commit && (hit_q || (ins_new && emp_q));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lkv_pkg::ST_INIT;
			cnt_q    <= '0;
			rd_vld_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q  <= state_nx;
			rd_vld_q <= (state_q == lkv_pkg::ST_SCAN);
			// advance the slot counter through every sweep, rewind it in every other state
			if (state_q == lkv_pkg::ST_INIT || state_q == lkv_pkg::ST_SCAN ||
			    state_q == lkv_pkg::ST_CLEAR) begin
				cnt_q <= last_slot ? '0 : cnt_q + AW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (commit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload and scan bookkeeping
	always_ff @(posedge clk) begin
		rd_idx_q <= cnt_q;
		if (in_acc) begin
			req_q   <= lkv_pkg::req_t'(s_tuser);
			key_q   <= s_tdata[63:0];
			value_q <= s_tdata[127:64];
			hit_q   <= 1'b0;
			emp_q   <= 1'b0;
		end else if (rd_vld_q) begin
			// keep only the first key match and the first empty slot
			if (key_eq && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_q;
				hit_val_q <= val_rdata;
			end
			if (val_zero && !emp_q) begin
				emp_q     <= 1'b1;
				emp_idx_q <= rd_idx_q;
			end
		end
		if (commit) begin
			m_tdata    <= (req_q == lkv_pkg::REQ_GET && hit_q) ? hit_val_q : '0;
			m_tuser[0] <= ins_full;
		end
	end

endmodule

`default_nettype wire

/* dv/linear_key_value_table_core_test.sv */
// ----------------------------------------------------------------------------
// linear_key_value_table_core_test - regression for the linear key/value table
// Streams insert, get, clear and unused requests into the table, predicts each
// result word from a private copy of both stores and checks every word that
// leaves the master side. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_key_value_table_core_test;

	import lkv_pkg::*;

	localparam int unsigned SLOTS      = 32;
	localparam int unsigned POOL_SIZE  = 40;
	localparam int unsigned RANDOM_REQS = 925;
	localparam int unsigned DRAIN_CYCLES = 3 * (SLOTS + 3);
	localparam int unsigned SHOWN_MISMATCHES = 10;
	// request code with no operation behind it
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// one expected result word
	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             table_full;
	} table_reply_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors both stores and queues the replies they imply.
	// ------------------------------------------------------------------------
	class table_scoreboard;
		logic [KEY_W-1:0] key_slots[SLOTS];
		logic [VAL_W-1:0] value_slots[SLOTS];
		table_reply_t     replies[$];
		int unsigned      mismatches;
		int unsigned      words_checked;
		int unsigned      inserts, gets, clears, unused, drops, hits;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				key_slots[i]   = '0;
				value_slots[i] = '0;
			end
			replies       = {};
			mismatches    = 0;
			words_checked = 0;
			inserts = 0; gets = 0; clears = 0; unused = 0; drops = 0; hits = 0;
		endfunction

		// first slot holding key k, or SLOTS when the key is absent
		function int find_key(logic [KEY_W-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (key_slots[i] == k)
					return i;
			return SLOTS;
		endfunction

		// first slot whose value is zero, or SLOTS when the table is full
		function int find_empty();
			for (int i = 0; i < SLOTS; i++)
				if (value_slots[i] == '0)
					return i;
			return SLOTS;
		endfunction

		// apply one accepted request and queue its reply
		function void note_request(logic [REQ_W-1:0] code, logic [KEY_W-1:0] k,
				logic [VAL_W-1:0] v);
			table_reply_t r;
			int slot;
			r = '0;
			case (code)
				REQ_INSERT: begin
					inserts++;
					slot = find_key(k);
					if (slot < SLOTS) begin
						value_slots[slot] = v;
					end else if (v != '0) begin
						slot = find_empty();
						if (slot < SLOTS) begin
							key_slots[slot]   = k;
							value_slots[slot] = v;
						end else begin
							r.table_full = 1'b1;
							drops++;
						end
					end
				end
				REQ_GET: begin
					gets++;
					slot = find_key(k);
					if (slot < SLOTS)
						r.read_value = value_slots[slot];
					if (r.read_value != '0)
						hits++;
				end
				REQ_CLEAR: begin
					clears++;
					for (int i = 0; i < SLOTS; i++)
						value_slots[i] = '0;
				end
				default: unused++;
			endcase
			replies.push_back(r);
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES)
				$display("%0t: mismatch: %s", $time, what);
		endfunction

		// compare one result word with the oldest queued reply
		function void check_result(logic [VAL_W-1:0] rd, logic full);
			table_reply_t want;
			if (replies.size() == 0) begin
				report($sformatf("unexpected word read_value %h table_full %b", rd, full));
				return;
			end
			want = replies.pop_front();
			words_checked++;
			if (rd !== want.read_value)
				report($sformatf("read_value expected %h actual %h", want.read_value, rd));
			if (full !== want.table_full)
				report($sformatf("table_full expected %b actual %b", want.table_full, full));
		endfunction

		function int pending();
			return replies.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block ports; every input starts at a known value.
	// ------------------------------------------------------------------------
	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [127:0]       s_tdata  = '0;   // [63:0] key, [127:64] value
	logic [1:0]         s_tuser  = '0;   // [1:0] req_type
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [63:0]        m_tdata;         // [63:0] read_value
	logic [0:0]         m_tuser;         // [0] table_full

	// no idling on either side while this is set
	bit                 steady   = 1'b0;

	table_scoreboard    sb;
	logic [KEY_W-1:0]   key_pool[POOL_SIZE];
	int unsigned        sent     = 0;

	linear_key_value_table_core #(
		.CAPACITY(SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watch both handshakes on the edge where they complete; values read here
	// are the ones the block sampled, since every driver uses nonblocking updates.
	// Also pick the receiver's readiness for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[63:0], s_tdata[127:64]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser[0]);
			m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 26);
		end
	end

	// random 64-bit word
	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// value with a bias toward zero (remove) and all ones
	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return '0;
		if (roll < 20)
			return '1;
		return rand64();
	endfunction

	// Offer one request word; idle first at random, then hold it until taken.
	// Valid stays high into the next word when no idle falls between them.
	task automatic send_request(logic [REQ_W-1:0] code, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		while (!steady && $urandom_range(0, 99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= {v, k};
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
	endtask

	// Refill the table after a clear until it overflows, then probe it.
	// Stale keys from earlier runs get reused, so the fill order varies.
	task automatic fill_run();
		int unsigned base;
		send_request(REQ_CLEAR, rand64(), rand64());
		base = $urandom_range(0, POOL_SIZE - 1);
		for (int i = 0; i < SLOTS + 2; i++)
			send_request(REQ_INSERT, key_pool[(base + i) % POOL_SIZE], rand64() | 64'd1);
		for (int i = 0; i < 4; i++)
			send_request(REQ_GET, key_pool[$urandom_range(0, POOL_SIZE - 1)], rand64());
		// free a slot, then take it with a new key
		send_request(REQ_INSERT, key_pool[base], '0);
		send_request(REQ_INSERT, rand64(), rand64() | 64'd1);
	endtask

	// A run of mixed requests, mostly on pooled keys so that hits are common.
	task automatic mixed_run(int unsigned n);
		int unsigned roll;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			k    = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (roll < 45)
				send_request(REQ_INSERT, k, pick_value());
			else if (roll < 85)
				send_request(REQ_GET, k, rand64());
			else if (roll < 89)
				send_request(REQ_CLEAR, rand64(), rand64());
			else if (roll < 94)
				send_request(REQ_UNUSED, rand64(), rand64());
			else if (roll < 97)
				send_request(REQ_INSERT, rand64(), pick_value());
			else
				send_request(REQ_GET, rand64(), rand64());
		end
	endtask

	initial begin
		#10_000_000;
		$display("linear_key_value_table_core regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'd1;
		key_pool[3] = 64'h8000_0000_0000_0000;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = rand64();

		// hold reset low, then release it; the block then sweeps its stores
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: key zero matches slot zero straight after reset
		send_request(REQ_GET,    '0, '0);
		send_request(REQ_INSERT, '0, '1);
		send_request(REQ_GET,    '0, '0);
		send_request(REQ_INSERT, '1, 64'd1);
		send_request(REQ_GET,    '1, '1);
		// zero value for an absent key changes nothing
		send_request(REQ_INSERT, 64'h5555_5555_5555_5555, '0);
		send_request(REQ_GET,    64'h5555_5555_5555_5555, '0);
		send_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
		// remove a key; its slot stays matched through the stale key
		send_request(REQ_INSERT, '1, '0);
		send_request(REQ_GET,    '1, '0);
		send_request(REQ_INSERT, 64'h1234, 64'd7);
		send_request(REQ_GET,    64'h1234, '0);
		send_request(REQ_UNUSED, '1, '1);
		// clear keeps the keys; a re-insert lands on the stale slot
		send_request(REQ_CLEAR,  '0, '0);
		send_request(REQ_GET,    64'hAAAA_AAAA_AAAA_AAAA, '0);
		send_request(REQ_GET,    64'h1234, '0);
		send_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(REQ_GET,    64'hAAAA_AAAA_AAAA_AAAA, '1);
		send_request(REQ_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		send_request(REQ_GET,    64'h8000_0000_0000_0000, '0);
		send_request(REQ_GET,    '0, '1);
		send_request(REQ_CLEAR,  '1, '1);

		// random part: mixed runs with fill-to-overflow runs between them,
		// and a stretch in the middle with no idling on either side
		while (sent < RANDOM_REQS) begin
			steady = (sent >= 350 && sent < 500);
			if ($urandom_range(0, 99) < 12)
				fill_run();
			else
				mixed_run(20);
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		// drain: wait for every reply, then watch for stray words
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d inserts, %0d gets, %0d clears, %0d unused codes",
			sent, sb.inserts, sb.gets, sb.clears, sb.unused);
		$display("%0d words checked, %0d get hits, %0d inserts dropped on a full table, %0d mismatches",
			sb.words_checked, sb.hits, sb.drops, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("linear_key_value_table_core regression: pass");
		end else begin
			$display("linear_key_value_table_core regression: fail");
		end
		$finish;
	end

endmodule
